// ===== sv/itda_pkg.sv =====
// ----------------------------------------------------------------------------
// itda_pkg
// Shared types and character codes for the integer to decimal text unit.
// ----------------------------------------------------------------------------
package itda_pkg;

  typedef logic [3:0] digit_t;
  typedef logic [5:0] char_t;

  localparam char_t CHAR_MINUS = 6'd45;
  localparam char_t CHAR_ZERO  = 6'd48;
  localparam digit_t DIGIT_MAX = 4'd9;
  localparam digit_t DIGIT_ADJ_MIN = 4'd5;
  localparam digit_t DIGIT_ADJ = 4'd3;

endpackage

// ===== sv/int_to_decimal_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_unit
// Formats a signed integer as decimal ASCII text, one character per transfer.
// ----------------------------------------------------------------------------
// Sequence: a load, then double-dabble conversion of the magnitude (one bit per cycle),
// a leading-zero skip, an optional minus sign, then one character per cycle while the
// output is not stalled. A new number is accepted only when the unit is idle again,
// once the last character of the number before it has been issued to the output.
// Reset: synchronous, clears the sequencer and the output valid flag.
module int_to_decimal_ascii_unit
  import itda_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         value_valid,
  output logic                         value_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         char_valid,
  input  logic                         char_ready,
  output logic [5:0]                   character,
  output logic                         last
);

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int REM_W = $clog2(MAX_DIGITS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]            state;
  logic [VALUE_BITS-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [CNT_W-1:0]      bit_cnt;
  logic [REM_W-1:0]      remaining;
  logic                  neg;
  logic                  ovf;
  logic                  slot_free;
  digit_t                top_digit;
  digit_t                emit_digit;

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= DIGIT_ADJ_MIN) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + DIGIT_ADJ;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign top_digit   = bcd[BCD_W-1 -: 4];
  assign emit_digit  = (top_digit > DIGIT_MAX) ? DIGIT_MAX : top_digit;
  assign slot_free   = !char_valid || char_ready;
  assign value_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_valid <= 1'b0;
    end else begin
      if (char_valid && char_ready && state != ST_SIGN && state != ST_EMIT) begin
        char_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (value_valid) begin
            neg       <= value[VALUE_BITS-1];
            mag       <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
            bcd       <= '0;
            ovf       <= 1'b0;
            bit_cnt   <= CNT_W'(VALUE_BITS);
            remaining <= REM_W'(MAX_DIGITS);
            state     <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd     <= {bcd_adj[BCD_W-2:0], mag[VALUE_BITS-1]};
          ovf     <= ovf | bcd_adj[BCD_W-1];
          mag     <= {mag[VALUE_BITS-2:0], 1'b0};
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == CNT_W'(1)) begin
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (!ovf && remaining > REM_W'(1) && top_digit == '0) begin
            bcd       <= {bcd[BCD_W-5:0], 4'd0};
            remaining <= remaining - 1'b1;
          end else begin
            state <= neg ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            char_valid <= 1'b1;
            character  <= CHAR_MINUS;
            last       <= 1'b0;
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            char_valid <= 1'b1;
            character  <= CHAR_ZERO + {2'b00, emit_digit};
            last       <= (remaining == REM_W'(1));
            bcd        <= {bcd[BCD_W-5:0], 4'd0};
            remaining  <= remaining - 1'b1;
            if (remaining == REM_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_load_starts_conv: assert property (@(posedge clk) disable iff (rst)
    value_valid && value_ready |=> state == ST_CONV && bit_cnt == CNT_W'(VALUE_BITS))
    else $error("conversion did not start with a full bit count");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> remaining != '0)
    else $error("emitting with no digits left");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    char_valid && character == CHAR_MINUS |-> !last)
    else $error("minus sign flagged as the final character");

  a_overflow_keeps_all: assert property (@(posedge clk) disable iff (rst)
    state == ST_SKIP && ovf |-> remaining == REM_W'(MAX_DIGITS))
    else $error("leading digits skipped on an overflowed value");

endmodule

// ===== verif/int_to_decimal_ascii_checker.sv =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_checker
// Watches the number and character channels of the decimal text unit, builds
// the expected text of every accepted number and compares each character
// transfer against it in order, counting mismatches for the testbench top.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_checker
  import itda_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         value_valid,
  input  logic                         value_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         char_valid,
  input  logic                         char_ready,
  input  logic [5:0]                   character,
  input  logic                         last,
  output int                           mismatch_count,
  output int                           pending_chars
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    char_t character;
    logic  last;
  } text_char_t;

  text_char_t expected_text [$];
  text_char_t wanted;

  initial begin
    mismatch_count = 0;
    pending_chars = 0;
  end

  // The magnitude is taken as unsigned, so the most negative value needs no
  // special handling.
  function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] number);
    logic [VALUE_BITS-1:0] magnitude;
    logic [63:0]           rest;
    digit_t                digits [MAX_DIGITS];
    int                    count;
    text_char_t            entry;
    magnitude = number[VALUE_BITS-1] ? (~number + 1'b1) : number;
    rest = 64'(magnitude);
    count = 0;
    do begin
      digits[count] = digit_t'(rest % 10);
      count++;
      rest = rest / 10;
    end while (rest != 0 && count < MAX_DIGITS);
    if (number[VALUE_BITS-1]) begin
      entry.character = CHAR_MINUS;
      entry.last = 1'b0;
      expected_text.push_back(entry);
    end
    for (int i = count - 1; i >= 0; i--) begin
      entry.character = CHAR_ZERO + char_t'(digits[i]);
      entry.last = (i == 0);
      expected_text.push_back(entry);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_text.delete();
      mismatch_count <= 0;
      pending_chars <= 0;
    end else begin
      if (value_valid && value_ready) begin
        queue_decimal_text(value);
      end
      if (char_valid && char_ready) begin
        if (expected_text.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: unexpected character %0d last %0b", $realtime, character, last);
          end
          mismatch_count <= mismatch_count + 1;
        end else begin
          wanted = expected_text.pop_front();
          if (character !== wanted.character || last !== wanted.last) begin
            if (mismatch_count < 10) begin
              $display("%0t: character expected %0d last %0b, got %0d last %0b",
                       $realtime, wanted.character, wanted.last, character, last);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      pending_chars <= expected_text.size();
    end
  end

endmodule

// ===== verif/tb_int_to_decimal_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// tb_int_to_decimal_ascii_unit
// Drives directed and random signed numbers into the decimal text unit in
// bursts with random gaps, stalls the character side on changing patterns,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_int_to_decimal_ascii_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_BITS     = 32;
  localparam int MAX_DIGITS     = 10;
  localparam int RANDOM_NUMBERS = 360;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 64;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PERIODIC,
    READY_SPARSE
  } ready_mode_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         value_valid = 1'b0;
  logic                         value_ready;
  logic signed [VALUE_BITS-1:0] value = '0;
  logic                         char_valid;
  logic                         char_ready = 1'b0;
  logic [5:0]                   character;
  logic                         last;
  int                           mismatch_count;
  int                           pending_chars;
  int                           idle_cycles = 0;
  int                           burst_left = 0;
  int                           ready_span = 0;
  ready_mode_t                  ready_mode = READY_ALWAYS;

  always #5 clk = ~clk;

  int_to_decimal_ascii_unit #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .value_valid(value_valid),
    .value_ready(value_ready),
    .value      (value),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .character  (character),
    .last       (last)
  );

  int_to_decimal_ascii_checker #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .value_valid   (value_valid),
    .value_ready   (value_ready),
    .value         (value),
    .char_valid    (char_valid),
    .char_ready    (char_ready),
    .character     (character),
    .last          (last),
    .mismatch_count(mismatch_count),
    .pending_chars (pending_chars)
  );

  always @(posedge clk) begin
    if (rst) begin
      char_ready <= 1'b0;
      ready_span <= 0;
      ready_mode <= READY_ALWAYS;
    end else begin
      if (ready_span == 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 3));
        ready_span <= $urandom_range(20, 200);
      end else begin
        ready_span <= ready_span - 1;
      end
      case (ready_mode)
        READY_ALWAYS: char_ready <= 1'b1;
        READY_RANDOM: char_ready <= 1'($urandom_range(0, 1));
        READY_PERIODIC: char_ready <= (ready_span % 4) != 0;
        default: char_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((value_valid && value_ready) || (char_valid && char_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_number(input logic [VALUE_BITS-1:0] number);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 60);
      value_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    value_valid <= 1'b1;
    value <= number;
    do @(posedge clk); while (!value_ready);
    burst_left--;
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_number();
    logic [VALUE_BITS-1:0] number;
    longint                power;
    int                    exponent;
    case ($urandom_range(0, 3))
      0: number = $urandom;
      1: number = $urandom_range(0, 999);
      2: begin
        power = 1;
        exponent = $urandom_range(0, 9);
        repeat (exponent) power = power * 10;
        power = power - 1 + $urandom_range(0, 2);
        number = power[VALUE_BITS-1:0];
      end
      default: number = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      number = ~number + 1'b1;
    end
    return number;
  endfunction

  initial begin
    int directed_numbers [23] = '{
      0, 1, -1, 9, -9, 10, -10, 99, -100, 101, 65535, -65536,
      999999999, -999999999, 1000000000, -1000000000, 1234567890, -1234567890,
      2147483647, -2147483647, 32'sh8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_numbers[i]) begin
      send_number(directed_numbers[i]);
    end
    repeat (RANDOM_NUMBERS) begin
      send_number(pick_number());
    end
    value_valid <= 1'b0;
    do @(posedge clk); while (pending_chars != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/itda_pkg.sv
sv/int_to_decimal_ascii_unit.sv
verif/int_to_decimal_ascii_checker.sv
verif/tb_int_to_decimal_ascii_unit.sv
